// File: hw/rtl/url_component_tagger_assert.svh
// Assertion macros for the URL component tagger.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef URL_COMPONENT_TAGGER_ASSERT_SVH
`define URL_COMPONENT_TAGGER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define UTG_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("utg check failed (same cycle)");

// Next-cycle implication, disabled during reset.
`define UTG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("utg check failed (next cycle)");

`endif

// File: hw/rtl/utg_pkg.sv
// Package for the URL component tagger: phase and tag codes, state and
// result structs, character constants and class functions. No dependencies.
`timescale 1ns / 1ps

package utg_pkg;

   typedef enum logic [3:0] {
      PH_SCHEME = 4'd0,
      PH_SLASH1 = 4'd1,
      PH_SLASH2 = 4'd2,
      PH_UOH    = 4'd3,
      PH_PASS   = 4'd4,
      PH_HOST   = 4'd5,
      PH_POP    = 4'd6,
      PH_PORT   = 4'd7,
      PH_PATH   = 4'd8,
      PH_QUERY  = 4'd9,
      PH_FRAG   = 4'd10
   } phase_type;

   typedef enum logic [3:0] {
      COMP_DELIM   = 4'd0,
      COMP_SCHEME  = 4'd1,
      COMP_UOH     = 4'd2,
      COMP_USER    = 4'd3,
      COMP_PASS    = 4'd4,
      COMP_HOST    = 4'd5,
      COMP_POP     = 4'd6,
      COMP_PORT    = 4'd7,
      COMP_PATH    = 4'd8,
      COMP_QUERY   = 4'd9,
      COMP_FRAG    = 4'd10
   } comp_type;

   // Resolve codes
   localparam logic [1:0] RES_NONE = 2'd0;
   localparam logic [1:0] R1_USER  = 2'd1;
   localparam logic [1:0] R1_HOST  = 2'd2;
   localparam logic [1:0] R2_PORT  = 2'd1;
   localparam logic [1:0] R2_PASS  = 2'd2;

   // "https" prefix tracker
   localparam logic [2:0] MATCH_DONE = 3'd5;
   localparam logic [2:0] MATCH_BAD  = 3'd7;

   localparam logic [15:0] PORT_HTTP  = 16'd80;
   localparam logic [15:0] PORT_HTTPS = 16'd443;
   localparam logic [15:0] PORT_MAX   = 16'hFFFF;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_AT      = 8'h40;
   localparam logic [7:0] CH_TILDE   = 8'h7E;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_QUEST   = 8'h3F;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_UNDER   = 8'h5F;

   typedef struct packed {
      phase_type   phase;
      logic        valid;
      logic [15:0] port_accum;
      logic        port_has_digits;
      logic [2:0]  match_pos;
      logic        host_seen;
      logic        uoh_pending;
      logic        pop_pending;
   } utg_state_type;

   localparam utg_state_type STATE_RESET = '{
      phase:           PH_SCHEME,
      valid:           1'b1,
      port_accum:      16'd0,
      port_has_digits: 1'b0,
      match_pos:       3'd0,
      host_seen:       1'b0,
      uoh_pending:     1'b0,
      pop_pending:     1'b0
   };

   typedef struct packed {
      logic [7:0]  char_out;
      comp_type    component;
      logic [1:0]  first_run_resolve;
      logic [1:0]  second_run_resolve;
      logic        still_valid;
      logic        done_res;
      logic [15:0] port_number;
      logic        scheme_is_https;
   } utg_result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
             ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_unres(input logic [7:0] c);
      return is_alnum(c) || (c == CH_MINUS) || (c == CH_DOT) ||
             (c == CH_UNDER) || (c == CH_TILDE);
   endfunction

   // Byte of "https" at a given prefix position
   function automatic logic [7:0] https_char(input logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0:    ch = 8'h68;
         3'd1:    ch = 8'h74;
         3'd2:    ch = 8'h74;
         3'd3:    ch = 8'h70;
         3'd4:    ch = 8'h73;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// File: hw/rtl/utg_if.sv
// Valid/ready channel interfaces for the URL component tagger.
// Request: one URL byte and last flag. Response: the tagged byte.
`timescale 1ns / 1ps

interface utg_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       is_last;

   modport source (output valid, char_in, is_last, input ready);
   modport sink   (input valid, char_in, is_last, output ready);
endinterface

interface utg_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  char_out;
   logic [3:0]  component;
   logic [1:0]  first_run_resolve;
   logic [1:0]  second_run_resolve;
   logic        still_valid;
   logic        done_res;
   logic [15:0] port_number;
   logic        scheme_is_https;

   modport source (output valid, char_out, component, first_run_resolve,
                   second_run_resolve, still_valid, done_res, port_number,
                   scheme_is_https, input ready);
   modport sink   (input valid, char_out, component, first_run_resolve,
                   second_run_resolve, still_valid, done_res, port_number,
                   scheme_is_https, output ready);
endinterface

// File: hw/rtl/utg_port_digit.sv
// Decimal port accumulator step: port*10 + digit, saturating at 65535.
// Depends on utg_pkg.
`timescale 1ns / 1ps

module utg_port_digit import utg_pkg::*; (
   input  logic [15:0] port_cur,
   input  logic [7:0]  char_byte,
   output logic [15:0] port_next
);

   logic [19:0] sum;

   // x*10 as two shifts; low nibble of an ASCII digit is its value
   assign sum = {1'b0, port_cur, 3'b000} + {3'b000, port_cur, 1'b0} +
                {16'd0, char_byte[3:0]};

   assign port_next = (sum > {4'd0, PORT_MAX}) ? PORT_MAX : sum[15:0];

endmodule

// File: hw/rtl/utg_step.sv
// One-byte parse step: next parser state and tagged result for a byte.
// Depends on utg_pkg and utg_port_digit.
`timescale 1ns / 1ps

module utg_step import utg_pkg::*; (
   input  utg_state_type  cur,
   input  logic [7:0]     char_byte,
   input  logic           last_byte,
   output utg_state_type  nxt,
   output utg_result_type res
);

   logic [15:0] port_digit_val;

   utg_port_digit u_digit (
      .port_cur  (cur.port_accum),
      .char_byte (char_byte),
      .port_next (port_digit_val)
   );

   always_comb begin
      utg_state_type st;
      comp_type      comp;
      logic [1:0]    r1;
      logic [1:0]    r2;
      logic          bad;
      logic [15:0]   port;

      st   = cur;
      comp = COMP_DELIM;
      r1   = RES_NONE;
      r2   = RES_NONE;
      bad  = 1'b0;
      port = 16'd0;

      if (cur.valid) begin
         unique case (cur.phase)
            PH_SCHEME: begin
               if (is_alnum(char_byte) || char_byte == CH_PLUS ||
                   char_byte == CH_MINUS || char_byte == CH_DOT) begin
                  comp = COMP_SCHEME;
                  if (cur.match_pos < MATCH_DONE &&
                      char_byte == https_char(cur.match_pos)) begin
                     st.match_pos = 3'(cur.match_pos + 3'd1);
                  end else begin
                     st.match_pos = MATCH_BAD;
                  end
               end else if (char_byte == CH_COLON) begin
                  st.phase = PH_SLASH1;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_SLASH1: begin
               if (char_byte == CH_SLASH) begin
                  st.phase = PH_SLASH2;
               end else if (is_alnum(char_byte)) begin
                  comp           = COMP_UOH;
                  st.uoh_pending = 1'b1;
                  st.phase       = PH_UOH;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_SLASH2: begin
               if (char_byte == CH_SLASH) begin
                  st.uoh_pending = 1'b1;
                  st.phase       = PH_UOH;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_UOH: begin
               if (is_unres(char_byte) || char_byte == CH_PERCENT) begin
                  comp = COMP_UOH;
               end else if (char_byte == CH_COLON) begin
                  st.pop_pending = 1'b1;
                  st.phase       = PH_POP;
               end else if (char_byte == CH_AT) begin
                  r1             = R1_USER;
                  st.uoh_pending = 1'b0;
                  st.phase       = PH_HOST;
               end else if (char_byte == CH_SLASH) begin
                  r1             = R1_HOST;
                  st.uoh_pending = 1'b0;
                  comp           = COMP_PATH;
                  st.phase       = PH_PATH;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_PASS: begin
               if (is_alnum(char_byte) || char_byte == CH_PERCENT) begin
                  comp = COMP_PASS;
               end else if (char_byte == CH_AT) begin
                  st.phase = PH_HOST;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_HOST: begin
               // bracketed (IPv6) host is not supported
               if (char_byte == CH_LBRACK && !cur.host_seen) begin
                  bad = 1'b1;
               end else if (is_unres(char_byte) || char_byte == CH_PERCENT) begin
                  comp         = COMP_HOST;
                  st.host_seen = 1'b1;
               end else if (char_byte == CH_COLON) begin
                  st.phase = PH_PORT;
               end else if (char_byte == CH_SLASH) begin
                  comp     = COMP_PATH;
                  st.phase = PH_PATH;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_POP: begin
               if (is_digit(char_byte)) begin
                  comp               = COMP_POP;
                  st.port_accum      = port_digit_val;
                  st.port_has_digits = 1'b1;
               end else if (char_byte == CH_SLASH) begin
                  r1             = R1_HOST;
                  r2             = R2_PORT;
                  st.uoh_pending = 1'b0;
                  st.pop_pending = 1'b0;
                  comp           = COMP_PATH;
                  st.phase       = PH_PATH;
               end else if (is_alnum(char_byte) || char_byte == CH_PERCENT) begin
                  // run was user:password after all; drop digits
                  r1                 = R1_USER;
                  r2                 = R2_PASS;
                  st.uoh_pending     = 1'b0;
                  st.pop_pending     = 1'b0;
                  st.port_accum      = 16'd0;
                  st.port_has_digits = 1'b0;
                  comp               = COMP_PASS;
                  st.phase           = PH_PASS;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_PORT: begin
               if (is_digit(char_byte)) begin
                  comp               = COMP_PORT;
                  st.port_accum      = port_digit_val;
                  st.port_has_digits = 1'b1;
               end else if (char_byte == CH_SLASH) begin
                  comp     = COMP_PATH;
                  st.phase = PH_PATH;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_PATH: begin
               if (char_byte == CH_HASH) begin
                  st.phase = PH_FRAG;
               end else if (char_byte == CH_QUEST) begin
                  st.phase = PH_QUERY;
               end else begin
                  comp = COMP_PATH;
               end
            end
            PH_QUERY: begin
               if (char_byte == CH_HASH) begin
                  st.phase = PH_FRAG;
               end else if (char_byte != CH_QUEST) begin
                  comp = COMP_QUERY;
               end
            end
            default: begin
               comp = COMP_FRAG;
            end
         endcase

         if (bad) begin
            st.valid       = 1'b0;
            comp           = COMP_DELIM;
            r1             = RES_NONE;
            r2             = RES_NONE;
            st.uoh_pending = 1'b0;
            st.pop_pending = 1'b0;
         end
      end

      // end of URL: close pending runs, pick effective port
      if (last_byte && st.valid) begin
         if (st.uoh_pending) r1 = R1_HOST;
         if (st.pop_pending) r2 = R2_PORT;
         if (st.port_has_digits) begin
            port = st.port_accum;
         end else begin
            port = (st.match_pos == MATCH_DONE) ? PORT_HTTPS : PORT_HTTP;
         end
      end

      res.char_out           = char_byte;
      res.component          = comp;
      res.first_run_resolve  = r1;
      res.second_run_resolve = r2;
      res.still_valid        = st.valid;
      res.done_res           = last_byte;
      res.port_number        = port;
      res.scheme_is_https    = st.valid && (st.match_pos == MATCH_DONE);

      nxt = last_byte ? STATE_RESET : st;
   end

endmodule

// File: hw/rtl/url_component_tagger.sv
// Top level of the URL component tagger: request register, parser state,
// response register. Depends on utg_pkg, utg_if, utg_step, assertion macros.
//
// Usage:
//  - req_chan carries one URL byte per request (char_in) plus is_last on
//    the final byte of a URL. URLs follow each other with no gap needed.
//  - rsp_chan returns exactly one tagged response per request, in order:
//    component tag, run resolves, running validity, and on the last byte
//    the effective port (given port, else 443 for https, else 80).
//  - Path: request register, parser step, then response register.
//  - Throughput: one request per cycle while rsp_chan.ready is high.
//    The per-byte parser update is a single pass of logic between the
//    request register and the response register, so state carries from
//    byte to byte each cycle.
//  - Stall: when rsp_chan.ready is low the response register holds; the
//    request register takes a byte only while it is empty, and req_chan.ready
//    stays low while it is full, until the response is taken.
//  - Reset (synchronous, active high): both registers empty, parser back
//    in scheme phase. After each last byte the parser also returns there.
`timescale 1ns / 1ps
`include "url_component_tagger_assert.svh"

module url_component_tagger import utg_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   utg_req_if.sink   req_chan,
   utg_rsp_if.source rsp_chan
);

   // request register
   logic           req_valid_ff;
   logic [7:0]     req_char_ff;
   logic           req_last_ff;

   // parser state
   utg_state_type  state_ff;
   utg_state_type  state_in;

   // response register
   logic           rsp_valid_ff;
   utg_result_type rsp_ff;
   utg_result_type rsp_in;

   logic           advance;

   // move the held request into the response register
   assign advance        = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !req_valid_ff || advance;

   utg_step u_step (
      .cur       (state_ff),
      .char_byte (req_char_ff),
      .last_byte (req_last_ff),
      .nxt       (state_in),
      .res       (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         if (req_chan.ready) begin
            req_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         req_char_ff <= req_chan.char_in;
         req_last_ff <= req_chan.is_last;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.char_out           = rsp_ff.char_out;
   assign rsp_chan.component          = rsp_ff.component;
   assign rsp_chan.first_run_resolve  = rsp_ff.first_run_resolve;
   assign rsp_chan.second_run_resolve = rsp_ff.second_run_resolve;
   assign rsp_chan.still_valid        = rsp_ff.still_valid;
   assign rsp_chan.done_res           = rsp_ff.done_res;
   assign rsp_chan.port_number        = rsp_ff.port_number;
   assign rsp_chan.scheme_is_https    = rsp_ff.scheme_is_https;

   // last byte leaves the parser in its reset state
   `UTG_ASSERT_NEXT(a_last_resets, clock, reset, advance && req_last_ff,
      state_ff == STATE_RESET)

   // a syntax error sticks until the end of the URL
   `UTG_ASSERT_NEXT(a_invalid_sticky, clock, reset,
      advance && !req_last_ff && !state_ff.valid, !state_ff.valid)

   // a pending port-or-password run exists only in its own phase
   `UTG_ASSERT_NOW(a_pop_phase, clock, reset, state_ff.pop_pending,
      state_ff.phase == PH_POP)

   // invalid URL never reports a port
   `UTG_ASSERT_NOW(a_invalid_no_port, clock, reset,
      rsp_valid_ff && !rsp_ff.still_valid, rsp_ff.port_number == 16'd0)

endmodule

// File: tb/tb_url_component_tagger.sv
// Self-checking testbench for url_component_tagger: byte-serial URLs in, one
// tagged response per byte out. Depends on utg_pkg, utg_if and the block RTL.
`timescale 1ns / 1ps

module tb_url_component_tagger;
   import utg_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;   // cycles with no handshake at all
   localparam int PHASE_BYTES    = 275;    // random bytes per idling phase
   localparam int TAIL_CYCLES    = 8;      // settle time after the last response
   localparam int MAX_REPORTS    = 10;

   // Idling per random phase: none, sender, receiver, both lightly.
   localparam int SEND_IDLE [4] = '{0, 75, 0, 6};
   localparam int RCV_STALL [4] = '{0, 0, 75, 6};

   localparam logic [39:0] HTTPS_WORD = "https";

   // ------------------------------------------------------------------
   // Scoreboard: tracks parser state per request and holds the tags due.
   // ------------------------------------------------------------------
   class tag_scoreboard;
      phase_type      phase;
      logic           url_ok;
      logic [15:0]    port_val;
      logic           port_digits;
      logic [2:0]     https_pos;
      logic           host_nonempty;
      logic           user_host_open;
      logic           port_pass_open;

      utg_result_type tags_due[$];
      int             errors;
      int             checked;
      int             urls;
      int             bad_urls;
      int             https_urls;

      function new();
         errors = 0;
         checked = 0;
         urls = 0;
         bad_urls = 0;
         https_urls = 0;
         restart();
      endfunction

      function void restart();
         phase = PH_SCHEME;
         url_ok = 1'b1;
         port_val = '0;
         port_digits = 1'b0;
         https_pos = '0;
         host_nonempty = 1'b0;
         user_host_open = 1'b0;
         port_pass_open = 1'b0;
      endfunction

      function bit dec_digit(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function bit letter_or_digit(logic [7:0] c);
         return dec_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction

      // RFC 3986 unreserved set
      function bit unreserved(logic [7:0] c);
         return letter_or_digit(c) || c == CH_MINUS || c == CH_DOT ||
                c == CH_UNDER || c == CH_TILDE;
      endfunction

      function void push_port_digit(logic [7:0] c);
         int unsigned v;
         v = port_val * 10 + (c - 8'h30);
         port_val = (v > 65535) ? PORT_MAX : v[15:0];
         port_digits = 1'b1;
      endfunction

      // Tag one byte and advance the parser state.
      function utg_result_type tag_byte(logic [7:0] c, logic last);
         utg_result_type r;
         logic bad;
         r = '0;
         bad = 1'b0;
         r.char_out = c;
         r.component = COMP_DELIM;
         r.first_run_resolve = RES_NONE;
         r.second_run_resolve = RES_NONE;
         if (url_ok) begin
            case (phase)
               PH_SCHEME: begin
                  if (letter_or_digit(c) || c == CH_PLUS || c == CH_MINUS || c == CH_DOT) begin
                     r.component = COMP_SCHEME;
                     if (https_pos < MATCH_DONE && c == HTTPS_WORD[8*(4-https_pos) +: 8])
                        https_pos = https_pos + 3'd1;
                     else
                        https_pos = MATCH_BAD;
                  end else if (c == CH_COLON) begin
                     phase = PH_SLASH1;
                  end else begin
                     bad = 1'b1;
                  end
               end
               PH_SLASH1: begin
                  if (c == CH_SLASH) begin
                     phase = PH_SLASH2;
                  end else if (letter_or_digit(c)) begin
                     // authority with no "//": the byte opens the user-or-host run
                     r.component = COMP_UOH;
                     user_host_open = 1'b1;
                     phase = PH_UOH;
                  end else begin
                     bad = 1'b1;
                  end
               end
               PH_SLASH2: begin
                  if (c == CH_SLASH) begin
                     user_host_open = 1'b1;
                     phase = PH_UOH;
                  end else begin
                     bad = 1'b1;
                  end
               end
               PH_UOH: begin
                  if (unreserved(c) || c == CH_PERCENT) begin
                     r.component = COMP_UOH;
                  end else if (c == CH_COLON) begin
                     port_pass_open = 1'b1;
                     phase = PH_POP;
                  end else if (c == CH_AT) begin
                     r.first_run_resolve = R1_USER;
                     user_host_open = 1'b0;
                     phase = PH_HOST;
                  end else if (c == CH_SLASH) begin
                     r.first_run_resolve = R1_HOST;
                     user_host_open = 1'b0;
                     r.component = COMP_PATH;
                     phase = PH_PATH;
                  end else begin
                     bad = 1'b1;
                  end
               end
               PH_PASS: begin
                  if (letter_or_digit(c) || c == CH_PERCENT) r.component = COMP_PASS;
                  else if (c == CH_AT) phase = PH_HOST;
                  else bad = 1'b1;
               end
               PH_HOST: begin
                  if (c == CH_LBRACK && !host_nonempty) begin
                     bad = 1'b1;   // IPv6 literal not supported
                  end else if (unreserved(c) || c == CH_PERCENT) begin
                     r.component = COMP_HOST;
                     host_nonempty = 1'b1;
                  end else if (c == CH_COLON) begin
                     phase = PH_PORT;
                  end else if (c == CH_SLASH) begin
                     r.component = COMP_PATH;
                     phase = PH_PATH;
                  end else begin
                     bad = 1'b1;
                  end
               end
               PH_POP: begin
                  if (dec_digit(c)) begin
                     r.component = COMP_POP;
                     push_port_digit(c);
                  end else if (c == CH_SLASH) begin
                     r.first_run_resolve = R1_HOST;
                     r.second_run_resolve = R2_PORT;
                     user_host_open = 1'b0;
                     port_pass_open = 1'b0;
                     r.component = COMP_PATH;
                     phase = PH_PATH;
                  end else if (letter_or_digit(c) || c == CH_PERCENT) begin
                     // letter after the colon: it was user:password after all
                     r.first_run_resolve = R1_USER;
                     r.second_run_resolve = R2_PASS;
                     user_host_open = 1'b0;
                     port_pass_open = 1'b0;
                     port_val = '0;
                     port_digits = 1'b0;
                     r.component = COMP_PASS;
                     phase = PH_PASS;
                  end else begin
                     bad = 1'b1;
                  end
               end
               PH_PORT: begin
                  if (dec_digit(c)) begin
                     r.component = COMP_PORT;
                     push_port_digit(c);
                  end else if (c == CH_SLASH) begin
                     r.component = COMP_PATH;
                     phase = PH_PATH;
                  end else begin
                     bad = 1'b1;
                  end
               end
               PH_PATH: begin
                  if (c == CH_HASH) phase = PH_FRAG;
                  else if (c == CH_QUEST) phase = PH_QUERY;
                  else r.component = COMP_PATH;
               end
               PH_QUERY: begin
                  if (c == CH_HASH) phase = PH_FRAG;
                  else if (c != CH_QUEST) r.component = COMP_QUERY;
               end
               default: r.component = COMP_FRAG;
            endcase
            if (bad) begin
               url_ok = 1'b0;
               r.component = COMP_DELIM;
               r.first_run_resolve = RES_NONE;
               r.second_run_resolve = RES_NONE;
               user_host_open = 1'b0;
               port_pass_open = 1'b0;
            end
         end

         // Last byte: close pending runs and report the effective port.
         if (last && url_ok) begin
            if (user_host_open) r.first_run_resolve = R1_HOST;
            if (port_pass_open) r.second_run_resolve = R2_PORT;
            if (port_digits) r.port_number = port_val;
            else r.port_number = (https_pos == MATCH_DONE) ? PORT_HTTPS : PORT_HTTP;
         end
         r.still_valid = url_ok;
         r.done_res = last;
         r.scheme_is_https = url_ok && (https_pos == MATCH_DONE);
         if (last) begin
            urls++;
            if (!url_ok) bad_urls++;
            if (r.scheme_is_https) https_urls++;
            restart();
         end
         return r;
      endfunction

      function void note_request(logic [7:0] c, logic last);
         tags_due.push_back(tag_byte(c, last));
      endfunction

      function void check_response(utg_result_type got);
         utg_result_type want;
         if (tags_due.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected response: byte %02h comp %0d", got.char_out, got.component);
            return;
         end
         want = tags_due.pop_front();
         checked++;
         if (got.char_out !== want.char_out || got.component !== want.component ||
             got.first_run_resolve !== want.first_run_resolve ||
             got.second_run_resolve !== want.second_run_resolve ||
             got.still_valid !== want.still_valid || got.done_res !== want.done_res ||
             got.port_number !== want.port_number ||
             got.scheme_is_https !== want.scheme_is_https) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display({"mismatch at response %0d: expected byte %02h comp %0d r1 %0d",
                         " r2 %0d ok %0b done %0b port %0d https %0b"},
                        checked, want.char_out, want.component, want.first_run_resolve,
                        want.second_run_resolve, want.still_valid,
                        want.done_res, want.port_number, want.scheme_is_https);
               $display("   actual byte %02h comp %0d r1 %0d r2 %0d ok %0b done %0b port %0d https %0b",
                        got.char_out, got.component, got.first_run_resolve,
                        got.second_run_resolve, got.still_valid, got.done_res,
                        got.port_number, got.scheme_is_https);
            end
         end
      endfunction

      function int pending();
         return tags_due.size();
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Clock, reset, channels, block
   // ------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   utg_req_if req_if ();
   utg_rsp_if rsp_if ();

   url_component_tagger i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   tag_scoreboard sb = new();

   int send_idle_pct = 0;
   int rcv_stall_pct = 0;
   int send_free = 0;       // requests left in a no-idle burst on the request side
   int rcv_free = 0;        // cycles left in a stall-free stretch on the response side
   int quiet_cycles = 0;
   int bytes_sent = 0;

   logic [7:0] url_text[$];

   initial begin
      req_if.valid = 1'b0;
      req_if.char_in = '0;
      req_if.is_last = 1'b0;
      rsp_if.ready = 1'b0;
   end

   // Response side backpressure, with occasional stall-free stretches.
   always @(posedge clock) begin
      if (rcv_free > 0) begin
         rcv_free <= rcv_free - 1;
         rsp_if.ready <= 1'b1;
      end else begin
         if ($urandom_range(99) < 3) rcv_free <= $urandom_range(8, 40);
         rsp_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
   end

   // Monitor both channels; every accepted request predicts one response.
   always @(posedge clock) begin
      utg_result_type seen;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_if.valid === 1'b1 && req_if.ready === 1'b1)
            sb.note_request(req_if.char_in, req_if.is_last);
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            seen = '{char_out: rsp_if.char_out,
                     component: comp_type'(rsp_if.component),
                     first_run_resolve: rsp_if.first_run_resolve,
                     second_run_resolve: rsp_if.second_run_resolve,
                     still_valid: rsp_if.still_valid,
                     done_res: rsp_if.done_res,
                     port_number: rsp_if.port_number,
                     scheme_is_https: rsp_if.scheme_is_https};
            sb.check_response(seen);
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                     quiet_cycles, sb.pending());
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Request driving
   // ------------------------------------------------------------------

   // One request; called at a rising edge, returns at the edge it is taken.
   task automatic send_byte(input logic [7:0] c, input logic last);
      while (send_free == 0 && $urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      if (send_free > 0) send_free--;
      else if ($urandom_range(99) < 3) send_free = $urandom_range(8, 40);
      req_if.valid <= 1'b1;
      req_if.char_in <= c;
      req_if.is_last <= last;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_url();
      foreach (url_text[i]) send_byte(url_text[i], i == url_text.size() - 1);
   endtask

   // Hold off requests until every response is back.
   task automatic drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic push_text(input string s);
      foreach (s[i]) url_text.push_back(s[i]);
   endtask

   function automatic logic [7:0] pick_from(input string set);
      return set[$urandom_range(set.len() - 1)];
   endfunction

   task automatic push_run(input string set, input int lo, input int hi);
      repeat ($urandom_range(lo, hi)) url_text.push_back(pick_from(set));
   endtask

   // Mostly well-formed URLs with random content; some noise, corruption
   // and truncation so that pending runs end on the last byte.
   task automatic make_url();
      int pick;
      bit slashes;
      bit userinfo;
      int pos;
      url_text.delete();
      pick = $urandom_range(99);
      if (pick < 8) begin
         push_run("", 0, 0);
         repeat ($urandom_range(1, 8)) url_text.push_back(8'($urandom_range(255)));
         return;
      end

      pick = $urandom_range(99);
      if (pick < 35) push_text("https");
      else if (pick < 55) push_text("http");
      else if (pick < 60) push_text("httpsx");
      else if (pick < 65) push_text("HTTPS");
      else push_run("ahtpsZ09+-.", 1, 4);
      url_text.push_back(CH_COLON);

      slashes = ($urandom_range(99) < 85);
      if (slashes) push_text("//");
      userinfo = ($urandom_range(99) < 40);
      if (userinfo) begin
         if (!slashes) url_text.push_back(pick_from("aZq09"));
         push_run("abZ09-._~%", 0, 4);
         if ($urandom_range(1)) begin
            url_text.push_back(CH_COLON);
            push_run("0123456789", 0, 3);
            push_run("aZ9%", 0, 3);
         end
         url_text.push_back(CH_AT);
      end
      if ($urandom_range(99) < 3) url_text.push_back(CH_LBRACK);
      if (!slashes && !userinfo) url_text.push_back(pick_from("aZq09"));
      push_run("abcxyzAZ09-._~%", 0, 5);
      if ($urandom_range(99) < 40) begin
         url_text.push_back(CH_COLON);
         if ($urandom_range(99) < 10) push_text("99999");
         else push_run("0123456789", 0, 6);
      end
      if ($urandom_range(99) < 70) begin
         url_text.push_back(CH_SLASH);
         push_run("az09/.-%~@:&=", 0, 6);
         if ($urandom_range(99) < 30) begin
            url_text.push_back(CH_QUEST);
            push_run("a=&?/:@", 0, 5);
         end
         if ($urandom_range(99) < 20) begin
            url_text.push_back(CH_HASH);
            push_run("a?#/x", 0, 4);
         end
      end

      if ($urandom_range(99) < 10) begin
         pos = $urandom_range(url_text.size() - 1);
         url_text[pos] = 8'($urandom_range(255));
      end
      if ($urandom_range(99) < 15) begin
         pos = $urandom_range(1, url_text.size());
         while (url_text.size() > pos) void'(url_text.pop_back());
      end
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: bracket opening an empty host, port overflow with both
      // runs still pending at the end, empty runs with an empty port and
      // repeated '?', and the byte extremes as a broken scheme.
      url_text.delete();
      push_text("h:a@[");
      send_url();
      url_text.delete();
      push_text("a:b:99999");
      send_url();
      url_text.delete();
      push_text("s://:/??#");
      send_url();
      url_text.delete();
      url_text.push_back(8'hFF);
      url_text.push_back(8'h00);
      send_url();
      drain();

      // Random URLs through the four idling phases; each phase ends with
      // the request side paused until all responses are back.
      for (int p = 0; p < 4; p++) begin
         int phase_bytes;
         send_idle_pct = SEND_IDLE[p];
         rcv_stall_pct = RCV_STALL[p];
         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) begin
            make_url();
            send_url();
            phase_bytes += url_text.size();
         end
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         $display("%0d responses never arrived", sb.pending());
         sb.errors++;
      end
      $display("%0d URLs, %0d bytes sent, %0d responses checked", sb.urls, bytes_sent,
               sb.checked);
      $display("%0d URLs rejected as malformed, %0d with an https scheme, %0d failures",
               sb.bad_urls, sb.https_urls, sb.errors);
      if (sb.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/utg_pkg.sv
hw/rtl/utg_if.sv
hw/rtl/utg_port_digit.sv
hw/rtl/utg_step.sv
hw/rtl/url_component_tagger.sv
tb/tb_url_component_tagger.sv
